// File: src/hprc_pkg.sv
// ----------------------------------------------------------------------------
// hprc_pkg: shared types and constants of the hazard pointer reclaimer
// Field widths, command and register codes, default sizes and the hazard
// table write request.
// ----------------------------------------------------------------------------
package hprc_pkg;

	// field widths
	localparam int CMD_W    = 2;
	localparam int THREAD_W = 3;
	localparam int SLOT_W   = 2;
	localparam int PTR_W    = 64;
	localparam int KIND_W   = 1;

	// stream word widths, padded to whole bytes
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 72;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam int PERIOD_W   = 5;
	localparam int CTR_W      = 6;

	localparam logic [CFG_IDX_W-1:0] REG_COLLECT_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCAN_PERIOD    = 2'd1;

	localparam logic                PERIOD_RESET = 1'b0;
	localparam logic [PERIOD_W-1:0] SCAN_PERIOD_RST = 5'd15;

	// commands
	localparam logic [CMD_W-1:0] CMD_RESERVE   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR     = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR_ALL = 2'd2;
	localparam logic [CMD_W-1:0] CMD_RETIRE    = 2'd3;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_FREED   = 1'b0;
	localparam logic [KIND_W-1:0] KIND_DROPPED = 1'b1;

	// default sizes
	localparam int THREADS_DEF = 8;
	localparam int SLOTS_DEF   = 4;
	localparam int DEPTH_DEF   = 64;

	// hazard table write request
	typedef struct packed {
		logic                set;
		logic                clr_all;
		logic [THREAD_W-1:0] thread;
		logic [SLOT_W-1:0]   slot;
		logic [PTR_W-1:0]    value;
	} haz_wr_t;

endpackage

// File: src/hprc_hazard_table.sv
// ----------------------------------------------------------------------------
// hprc_hazard_table: hazard slot table with a one-row compare unit
// Holds every thread's hazard slots. Each cycle one row (one thread's slots)
// is compared against a query pointer.
// ----------------------------------------------------------------------------
module hprc_hazard_table #(
	parameter int THREADS = hprc_pkg::THREADS_DEF,
	parameter int SLOTS   = hprc_pkg::SLOTS_DEF,
	localparam int TW     = (THREADS > 1) ? $clog2(THREADS) : 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  hprc_pkg::haz_wr_t        wr,
	input  logic [TW-1:0]            row,
	input  logic [hprc_pkg::PTR_W-1:0] query,
	output logic                     hit
);
	import hprc_pkg::*;

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [PTR_W-1:0] haz_q [THREADS][SLOTS];
	logic [TW-1:0]    wr_t;
	logic [SW-1:0]    wr_s;

	assign wr_t = TW'(wr.thread);
	assign wr_s = SW'(wr.slot);

	// slot writes; reset nulls every slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < THREADS; i++) begin
				for (int j = 0; j < SLOTS; j++) begin
					haz_q[i][j] <= '0;
				end
			end
		end else if (wr.set) begin
			haz_q[wr_t][wr_s] <= wr.value;
		end else if (wr.clr_all) begin
			for (int j = 0; j < SLOTS; j++) begin
				haz_q[wr_t][j] <= '0;
			end
		end
	end

	// compare the selected row against the query
	always_comb begin
		hit = 1'b0;
		for (int j = 0; j < SLOTS; j++) begin
			hit = hit | (haz_q[row][j] == query);
		end
	end

endmodule

// File: src/hazard_pointer_reclaimer_unit.sv
// ----------------------------------------------------------------------------
// hazard_pointer_reclaimer_unit: hazard pointer reclamation engine
// Reserve, clear and retire commands; periodic scans free unprotected
// retired pointers.
// ----------------------------------------------------------------------------
// Reserve, clear, clear-all and a retire that starts no scan leave the
// sequencer idle, and the input is ready again on the next cycle; a retire
// that is dropped at a full buffer passes through S_LAST to post its result.
// A retire that starts a scan walks the thread's retired buffer one entry at
// a time: each entry is read from the retired memory (S_RD), then compared
// against one hazard row at a time (S_CMP; one thread's slots are compared at
// once) until a row matches or the last row is passed, and an entry that is
// freed is posted from S_FREE; the scan closes through S_RD and, when a
// result is owed, S_LAST. There is a single shared row comparator; an output
// register lets the next word be accepted while a result still waits. The
// retired memory is not cleared after reset.
// ----------------------------------------------------------------------------
module hazard_pointer_reclaimer_unit #(
	parameter int THREADS          = hprc_pkg::THREADS_DEF,
	parameter int SLOTS_PER_THREAD = hprc_pkg::SLOTS_DEF,
	parameter int RETIRE_DEPTH     = hprc_pkg::DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [hprc_pkg::IN_DATA_W-1:0]  s_tdata,  // thread, slot, pointer
	input  logic [hprc_pkg::CMD_W-1:0]      s_tuser,  // cmd
	// result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [hprc_pkg::OUT_DATA_W-1:0] m_tdata,  // freed_pointer, owner_thread
	output logic [hprc_pkg::KIND_W-1:0]     m_tuser,  // kind
	output logic                            m_tlast,
	// configuration
	input  logic                            cfg_we,
	input  logic [hprc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hprc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import hprc_pkg::*;

	localparam int TW  = (THREADS > 1) ? $clog2(THREADS) : 1;
	localparam int CW  = $clog2(RETIRE_DEPTH + 1);
	localparam int MEM = THREADS * RETIRE_DEPTH;
	localparam int AW  = $clog2(MEM);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_RD   = 5'b00010,
		S_CMP  = 5'b00100,
		S_FREE = 5'b01000,
		S_LAST = 5'b10000
	} state_t;

	state_t state_q;

	// configuration registers
	logic                collect_en_q;
	logic [PERIOD_W-1:0] period_q;

	// per-thread state
	logic [CW-1:0]    count_q [THREADS];
	logic [CTR_W-1:0] ctr_q   [THREADS];

	// current item
	logic [TW-1:0]       t_q;
	logic [THREAD_W-1:0] thr_q;
	logic [PTR_W-1:0]    p_q;
	logic                full_q;
	logic                drop_q;

	// scan walk
	logic [CW-1:0]    n_q, r_q, w_q;
	logic [TW-1:0]    row_q;
	logic [PTR_W-1:0] rd_q;
	logic             pend_valid_q;
	logic [PTR_W-1:0] pend_ptr_q;

	// output register
	logic                out_valid_q;
	logic [PTR_W-1:0]    out_ptr_q;
	logic [THREAD_W-1:0] out_thr_q;
	logic [KIND_W-1:0]   out_kind_q;
	logic                out_last_q;

	// retired pointer memory
	logic [PTR_W-1:0] ret_mem_q [MEM];
	logic             mem_we, mem_re;
	logic [AW-1:0]    mem_wa, mem_ra;
	logic [PTR_W-1:0] mem_wd;

	// input decode
	logic [CMD_W-1:0]    in_cmd;
	logic [THREAD_W-1:0] in_thr;
	logic [SLOT_W-1:0]   in_slot;
	logic [PTR_W-1:0]    in_ptr;
	logic [TW-1:0]       in_t;
	logic                acc, thr_ok, slot_ok, retire_go;
	logic [CW-1:0]       cur_cnt;
	logic                cur_full, trig;

	// control
	logic          out_free, load_out, hit;
	logic          scan_end, end_drop;
	haz_wr_t       haz_wr;
	logic [KIND_W-1:0] load_kind;
	logic [PTR_W-1:0]  load_ptr;
	logic              load_last;

	assign in_cmd  = s_tuser;
	assign in_thr  = s_tdata[THREAD_W-1:0];
	assign in_slot = s_tdata[THREAD_W +: SLOT_W];
	assign in_ptr  = s_tdata[THREAD_W + SLOT_W +: PTR_W];
	assign in_t    = TW'(in_thr);

	assign s_tready = (state_q == S_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign thr_ok   = 32'(in_thr) < THREADS;
	assign slot_ok  = 32'(in_slot) < SLOTS_PER_THREAD;

	assign cur_cnt  = count_q[in_t];
	assign cur_full = (cur_cnt == CW'(RETIRE_DEPTH));
	assign trig     = collect_en_q && (ctr_q[in_t] == {1'b0, period_q});
	assign retire_go = acc && thr_ok && (in_cmd == CMD_RETIRE) && (in_ptr != '0);

	assign out_free = !out_valid_q || m_tready;
	assign scan_end = (state_q == S_RD) && (r_q == n_q);
	assign end_drop = full_q && (w_q == CW'(RETIRE_DEPTH));

	// hazard table writes
	always_comb begin
		haz_wr.set     = acc && thr_ok && slot_ok &&
		                 ((in_cmd == CMD_RESERVE) || (in_cmd == CMD_CLEAR));
		haz_wr.clr_all = acc && thr_ok && (in_cmd == CMD_CLEAR_ALL);
		haz_wr.thread  = in_thr;
		haz_wr.slot    = in_slot;
		haz_wr.value   = (in_cmd == CMD_RESERVE) ? in_ptr : '0;
	end

	hprc_hazard_table #(
		.THREADS (THREADS),
		.SLOTS   (SLOTS_PER_THREAD)
	) u_haz (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (haz_wr),
		.row    (row_q),
		.query  (rd_q),
		.hit    (hit)
	);

	// memory port selection
	always_comb begin
		mem_we = 1'b0;
		mem_wa = AW'(t_q) * AW'(RETIRE_DEPTH) + AW'(w_q);
		mem_wd = rd_q;
		if (retire_go && !cur_full) begin
			mem_we = 1'b1;
			mem_wa = AW'(in_t) * AW'(RETIRE_DEPTH) + AW'(cur_cnt);
			mem_wd = in_ptr;
		end else if (state_q == S_CMP && hit) begin
			mem_we = 1'b1;
		end else if (scan_end && full_q && !end_drop) begin
			mem_we = 1'b1;
			mem_wd = p_q;
		end
	end

	assign mem_re = (state_q == S_RD) && (r_q != n_q);
	assign mem_ra = AW'(t_q) * AW'(RETIRE_DEPTH) + AW'(r_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ret_mem_q[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= ret_mem_q[mem_ra];
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collect_en_q <= 1'b1;
			period_q     <= SCAN_PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COLLECT_ENABLE: collect_en_q <= cfg_data[0];
				REG_SCAN_PERIOD:    period_q     <= cfg_data[PERIOD_W-1:0];
				default:            ;
			endcase
		end
	end

	// per-thread fill counts and retire counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < THREADS; i++) begin
				count_q[i] <= '0;
				ctr_q[i]   <= '0;
			end
		end else if (retire_go) begin
			if (!cur_full) begin
				count_q[in_t] <= cur_cnt + CW'(1);
			end
			ctr_q[in_t] <= trig ? CTR_W'(1) : ctr_q[in_t] + CTR_W'(1);
		end else if (scan_end) begin
			count_q[t_q] <= (full_q && !end_drop) ? w_q + CW'(1) : w_q;
		end
	end

	// result selection for the output register
	always_comb begin
		load_out  = 1'b0;
		load_kind = KIND_FREED;
		load_ptr  = pend_ptr_q;
		load_last = 1'b0;
		if (state_q == S_FREE && pend_valid_q && out_free) begin
			load_out = 1'b1;
		end else if (state_q == S_LAST && out_free) begin
			load_out  = 1'b1;
			load_last = 1'b1;
			if (drop_q) begin
				load_kind = KIND_DROPPED;
				load_ptr  = p_q;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pend_valid_q <= 1'b0;
			drop_q       <= 1'b0;
			full_q       <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (retire_go) begin
						full_q <= cur_full;
						if (trig) begin
							state_q <= S_RD;
						end else if (cur_full) begin
							drop_q  <= 1'b1;
							state_q <= S_LAST;
						end
					end
				end
				S_RD: begin
					if (scan_end) begin
						drop_q  <= end_drop;
						state_q <= (pend_valid_q || end_drop) ? S_LAST : S_IDLE;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (hit) begin
						state_q <= S_RD;
					end else if (row_q == TW'(THREADS - 1)) begin
						state_q <= S_FREE;
					end
				end
				S_FREE: begin
					if (!pend_valid_q || out_free) begin
						pend_valid_q <= 1'b1;
						state_q      <= S_RD;
					end
				end
				S_LAST: begin
					if (out_free) begin
						pend_valid_q <= 1'b0;
						drop_q       <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// scan datapath registers
	always_ff @(posedge clk) begin
		if (retire_go) begin
			t_q   <= in_t;
			thr_q <= in_thr;
			p_q   <= in_ptr;
			r_q   <= '0;
			w_q   <= '0;
			n_q   <= cur_full ? cur_cnt : cur_cnt + CW'(1);
		end
		if (state_q == S_RD) begin
			row_q <= '0;
		end else if (state_q == S_CMP && !hit) begin
			row_q <= row_q + TW'(1);
		end
		if (state_q == S_CMP && hit) begin
			w_q <= w_q + CW'(1);
			r_q <= r_q + CW'(1);
		end
		if (state_q == S_FREE && (!pend_valid_q || out_free)) begin
			pend_ptr_q <= rd_q;
			r_q        <= r_q + CW'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_ptr_q  <= load_ptr;
			out_thr_q  <= thr_q;
			out_kind_q <= load_kind;
			out_last_q <= load_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {{(OUT_DATA_W - PTR_W - THREAD_W){1'b0}}, out_thr_q, out_ptr_q};

endmodule

// File: src/hprc_checker.sv
// ----------------------------------------------------------------------------
// hprc_checker: port-level checks of the hazard pointer reclaimer
// Watches the result stream of the top level; bound to it below.
// ----------------------------------------------------------------------------
module hprc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [hprc_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic [hprc_pkg::KIND_W-1:0]     m_tuser,
	input logic                            m_tlast
);
	import hprc_pkg::*;

	// a stalled word stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word withdrawn while stalled");

	// a stalled word keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("result word changed while stalled");

	// a dropped retire is always the last result of its word
	a_drop_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_DROPPED) |-> m_tlast)
		else $error("dropped retire not marked last");

	// null pointers are never buffered, so never released
	a_no_null: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[PTR_W-1:0] != '0))
		else $error("null pointer released");

endmodule

bind hazard_pointer_reclaimer_unit hprc_checker u_hprc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// File: bench/reclaim_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reclaim_checker: result predictor and scoreboard for the reclaimer
// Watches the configuration port and both stream channels. Every accepted
// command word updates a private copy of the hazard slots, retired buffers
// and retire counters, and queues the freed or dropped pointers it causes.
// Each accepted result word is compared with the oldest queued one.
// ----------------------------------------------------------------------------
module reclaim_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [hprc_pkg::IN_DATA_W-1:0]  s_tdata,  // thread, slot, pointer
	input  logic [hprc_pkg::CMD_W-1:0]      s_tuser,  // cmd
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [hprc_pkg::OUT_DATA_W-1:0] m_tdata,  // freed_pointer, owner_thread
	input  logic [hprc_pkg::KIND_W-1:0]     m_tuser,  // kind
	input  logic                            m_tlast,
	input  logic                            cfg_we,
	input  logic [hprc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hprc_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              mismatches,
	output int                              pending
);
	import hprc_pkg::*;

	localparam int THREADS = THREADS_DEF;
	localparam int SLOTS   = SLOTS_DEF;
	localparam int DEPTH   = DEPTH_DEF;

	// input word layout
	localparam int SLOT_LSB = THREAD_W;
	localparam int PTR_LSB  = THREAD_W + SLOT_W;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [THREAD_W-1:0] owner;
		logic [PTR_W-1:0]    ptr;
		logic                last;
	} release_t;

	logic [PTR_W-1:0]    hazard [THREADS][SLOTS];
	logic [PTR_W-1:0]    backlog [THREADS][DEPTH];
	int                  backlog_n [THREADS];
	logic [CTR_W-1:0]    retire_ctr [THREADS];
	logic                collect_on;
	logic [PERIOD_W-1:0] period;

	release_t            expected_q [$];
	release_t            held;
	logic                held_ok;
	release_t            got;
	release_t            want;

	// true when any hazard slot of any thread protects ptr
	function automatic logic guarded(input logic [PTR_W-1:0] ptr);
		for (int t = 0; t < THREADS; t++)
			for (int s = 0; s < SLOTS; s++)
				if (hazard[t][s] == ptr)
					return 1'b1;
		return 1'b0;
	endfunction

	// hold back the newest result so the final one can get its last flag
	task automatic post_release(input logic [KIND_W-1:0] kind, input logic [PTR_W-1:0] ptr,
			input logic [THREAD_W-1:0] owner);
		if (held_ok)
			expected_q.insert(expected_q.size(), held);
		held    = {kind, owner, ptr, 1'b0};
		held_ok = 1'b1;
	endtask

	// apply one command word to the predicted state
	task automatic take_word(input logic [CMD_W-1:0] cmd, input logic [THREAD_W-1:0] t,
			input logic [SLOT_W-1:0] s, input logic [PTR_W-1:0] ptr);
		logic full;
		logic scan;
		int keep;
		logic [PTR_W-1:0] entry;
		held_ok = 1'b0;
		case (cmd)
			CMD_RESERVE: hazard[t][s] = ptr;
			CMD_CLEAR: hazard[t][s] = '0;
			CMD_CLEAR_ALL: begin
				for (int i = 0; i < SLOTS; i++)
					hazard[t][i] = '0;
			end
			default: begin
				// retire; null pointers are ignored
				if (ptr != '0) begin
					full = backlog_n[t] >= DEPTH;
					scan = collect_on && retire_ctr[t] == CTR_W'(period);
					if (!full) begin
						backlog[t][backlog_n[t]] = ptr;
						backlog_n[t]++;
					end
					if (scan) begin
						retire_ctr[t] = '0;
						keep = 0;
						for (int r = 0; r < backlog_n[t]; r++) begin
							entry = backlog[t][r];
							if (guarded(entry)) begin
								backlog[t][keep] = entry;
								keep++;
							end else begin
								post_release(KIND_FREED, entry, t);
							end
						end
						backlog_n[t] = keep;
					end
					// a full buffer gets another chance after the scan
					if (full) begin
						if (backlog_n[t] < DEPTH) begin
							backlog[t][backlog_n[t]] = ptr;
							backlog_n[t]++;
						end else begin
							post_release(KIND_DROPPED, ptr, t);
						end
					end
					retire_ctr[t] = retire_ctr[t] + 1'b1;
				end
			end
		endcase
		if (held_ok) begin
			held.last = 1'b1;
			expected_q.insert(expected_q.size(), held);
		end
	endtask

	// predict on accepted words, score accepted results
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < THREADS; t++) begin
				for (int s = 0; s < SLOTS; s++)
					hazard[t][s] = '0;
				backlog_n[t]  = 0;
				retire_ctr[t] = '0;
			end
			collect_on = 1'b1;
			period     = SCAN_PERIOD_RST;
			held_ok    = 1'b0;
			expected_q.delete();
			mismatches = 0;
			pending    = 0;
		end else begin
			// a word accepted at this edge still sees the old registers
			if (s_tvalid && s_tready)
				take_word(s_tuser, s_tdata[THREAD_W-1:0], s_tdata[SLOT_LSB +: SLOT_W],
					s_tdata[PTR_LSB +: PTR_W]);
			if (cfg_we) begin
				case (cfg_index)
					REG_COLLECT_ENABLE: collect_on = cfg_data[0];
					REG_SCAN_PERIOD: period = cfg_data[PERIOD_W-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got = {m_tuser, m_tdata[PTR_W +: THREAD_W], m_tdata[PTR_W-1:0], m_tlast};
				if (expected_q.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected word: kind %0d ptr %h owner %0d last %0b",
							got.kind, got.ptr, got.owner, got.last);
					mismatches++;
				end else begin
					want = expected_q.pop_front();
					if (got != want) begin
						if (mismatches < 10)
							$display({"word mismatch: expected kind %0d ptr %h owner %0d last %0b,",
								" got kind %0d ptr %h owner %0d last %0b"},
								want.kind, want.ptr, want.owner, want.last,
								got.kind, got.ptr, got.owner, got.last);
						mismatches++;
					end
				end
			end
			pending = expected_q.size();
		end
	end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for hazard_pointer_reclaimer_unit
// Drives a directed pass over every command and corner, a phase that fills
// one thread's retired buffer until retires are dropped, then random command
// words under several register settings, with random gaps and stalls.
// Results are scored by reclaim_checker.
// ----------------------------------------------------------------------------
module testbench;
	import hprc_pkg::*;

	// cycles to let a scan that frees nothing run out before idle actions
	localparam int SETTLE = 1000;

	// register indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [CMD_W-1:0]      s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [KIND_W-1:0]     m_tuser;
	logic                  m_tlast;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	logic                  calm;
	int                    mismatches;
	int                    pending;
	logic [PTR_W-1:0]      pool [16];

	hazard_pointer_reclaimer_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	reclaim_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		#(40_000_000);
		$display("status: fail");
		$finish;
	end

	// result side back-pressure
	always @(posedge clk) begin
		m_tready <= calm || $urandom_range(99) >= 12;
	end

	// mostly pool pointers so that retires hit reserved slots
	function automatic logic [PTR_W-1:0] pick_ptr();
		int r;
		r = $urandom_range(99);
		if (r < 6)
			return '0;
		if (r < 16)
			return {$urandom, $urandom};
		return pool[$urandom_range(15)];
	endfunction

	// one command word; valid stays up for back-to-back words
	task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [THREAD_W-1:0] thread,
			input logic [SLOT_W-1:0] slot, input logic [PTR_W-1:0] ptr);
		while (!calm && $urandom_range(99) < 12) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {{(IN_DATA_W-PTR_W-SLOT_W-THREAD_W){1'b0}}, ptr, slot, thread};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// stop sending and wait until every predicted word has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// spare indexes first (must be ignored), then both registers
	task automatic write_regs(input logic enable, input logic [PERIOD_W-1:0] period);
		cfg_we    <= 1'b1;
		cfg_index <= REG_SPARE_A;
		cfg_data  <= '1;
		@(posedge clk);
		cfg_index <= REG_SPARE_B;
		@(posedge clk);
		cfg_index <= REG_COLLECT_ENABLE;
		cfg_data  <= {{(CFG_DATA_W-1){1'b0}}, enable};
		@(posedge clk);
		cfg_index <= REG_SCAN_PERIOD;
		cfg_data  <= period;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// random mix, retire heavy
	task automatic run_random(input int count);
		int r;
		logic [CMD_W-1:0] cmd;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			cmd = r < 50 ? CMD_RETIRE : r < 75 ? CMD_RESERVE : r < 92 ? CMD_CLEAR : CMD_CLEAR_ALL;
			send_word(cmd, THREAD_W'($urandom_range(7)), SLOT_W'($urandom_range(3)),
				pick_ptr());
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = CMD_RESERVE;
		cfg_we    = 1'b0;
		cfg_index = REG_COLLECT_ENABLE;
		cfg_data  = '0;
		calm      = 1'b0;
		pool[0] = '1;
		pool[1] = 64'd1;
		for (int i = 2; i < 16; i++)
			pool[i] = {$urandom, $urandom};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: period 0 scans on the first retire of each thread
		write_regs(1'b1, 5'd0);
		send_word(CMD_RESERVE, 3'd0, 2'd0, '1);
		send_word(CMD_RESERVE, 3'd7, 2'd3, 64'd1);
		send_word(CMD_RESERVE, 3'd3, 2'd1, pool[2]);
		send_word(CMD_RETIRE, 3'd0, 2'd0, '1);         // protected, kept
		send_word(CMD_RETIRE, 3'd1, 2'd2, 64'd1);      // protected by another thread
		send_word(CMD_RETIRE, 3'd2, 2'd1, pool[3]);    // freed at once
		send_word(CMD_RETIRE, 3'd4, 2'd3, '0);         // null retire
		send_word(CMD_RETIRE, 3'd3, 2'd0, pool[2]);
		send_word(CMD_CLEAR, 3'd7, 2'd3, pool[6]);
		send_word(CMD_RESERVE, 3'd5, 2'd2, pool[4]);
		send_word(CMD_RESERVE, 3'd5, 2'd2, '0);        // null reserve clears
		send_word(CMD_CLEAR_ALL, 3'd0, 2'd1, pool[5]);
		send_word(CMD_CLEAR, 3'd3, 2'd1, '0);
		send_word(CMD_RETIRE, 3'd7, 2'd3, pool[4]);
		drain();
		// period 1: the second retire scans and frees two entries
		write_regs(1'b1, 5'd1);
		send_word(CMD_RETIRE, 3'd0, 2'd0, pool[5]);
		send_word(CMD_RETIRE, 3'd1, 2'd0, pool[6]);
		send_word(CMD_RETIRE, 3'd3, 2'd0, pool[7]);
		drain();

		// fill thread 6 with collection off until retires are dropped
		write_regs(1'b0, 5'd31);
		for (int i = 0; i < SLOTS_DEF; i++)
			send_word(CMD_RESERVE, 3'd5, SLOT_W'(i), pool[8 + i]);
		for (int i = 0; i < 70; i++)
			send_word(CMD_RETIRE, 3'd6, SLOT_W'($urandom_range(3)), pick_ptr());
		drain();
		// collection back on: drops until the counter meets the period
		write_regs(1'b1, 5'd31);
		for (int i = 0; i < 45; i++)
			send_word(CMD_RETIRE, 3'd6, SLOT_W'($urandom_range(3)), pick_ptr());
		drain();

		// random phases under several settings
		write_regs(1'b1, 5'd2);
		run_random(30);
		drain();
		calm <= 1'b1;
		write_regs(1'b1, 5'd0);
		run_random(25);
		drain();
		calm <= 1'b0;
		write_regs(1'b1, PERIOD_W'($urandom_range(31)));
		run_random(25);
		drain();
		write_regs(1'b1, SCAN_PERIOD_RST);
		run_random(25);
		drain();

		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: filelist.f
src/hprc_pkg.sv
src/hprc_hazard_table.sv
src/hazard_pointer_reclaimer_unit.sv
src/hprc_checker.sv
bench/reclaim_checker.sv
bench/testbench.sv
